// ----- sv/gbt_pkg.sv -----
// shared types and codes for the graph traversal block
package gbt_pkg;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_BFS = 2'd1;
  localparam logic [1:0] KIND_DFS = 2'd2;

  localparam logic [1:0] RES_STORED  = 2'd0;
  localparam logic [1:0] RES_DROPPED = 2'd1;
  localparam logic [1:0] RES_VISIT   = 2'd2;
  localparam logic [1:0] RES_EMPTY   = 2'd3;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ADD_RA,
    OP_ADD_WA,
    OP_ADD_WB,
    OP_ADD_LINK,
    OP_FIN_STORED,
    OP_FIN_DROP,
    OP_FIN_RUN,
    OP_RUN_INIT,
    OP_SCAN_NEXT,
    OP_START,
    OP_B_POP,
    OP_B_HEAD,
    OP_B_LIST,
    OP_B_ENT,
    OP_D_PUSH,
    OP_D_RD,
    OP_D_POP,
    OP_D_ENTRD,
    OP_D_ENT
  } gbt_op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       drop;
    logic       scan_done;
    logic       scan_hit;
    logic       q_empty;
    logic       list_end;
    logic       tgt_visited;
    logic       stack_empty;
    logic       top_done;
    logic       out_free;
  } gbt_status_t;

endpackage

// ----- sv/gbt_ctrl.sv -----
// controller state machine sequencing edge loads and traversals
module gbt_ctrl import gbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  gbt_status_t st,
  output gbt_op_t     op
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ADD_A, S_ADD_B, S_ADD_C, S_ADD_D,
    S_FIN_STORED, S_FIN_DROP, S_FIN_RUN, S_SCAN,
    S_B_POP, S_B_HEAD, S_B_LIST, S_B_ENT,
    S_D_PUSH, S_D_TOP, S_D_CHK, S_D_ENT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = OP_IDLE;
    cmd_ready = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.kind == KIND_ADD) begin
          state_next = st.drop ? S_FIN_DROP : S_ADD_A;
        end else if (st.kind == KIND_BFS || st.kind == KIND_DFS) begin
          op = OP_RUN_INIT;
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADD_A: begin
        op = OP_ADD_RA;
        state_next = S_ADD_B;
      end
      S_ADD_B: begin
        op = OP_ADD_WA;
        state_next = S_ADD_C;
      end
      S_ADD_C: begin
        op = OP_ADD_WB;
        state_next = S_ADD_D;
      end
      S_ADD_D: begin
        op = OP_ADD_LINK;
        state_next = S_FIN_STORED;
      end
      S_FIN_STORED: begin
        if (st.out_free) begin
          op = OP_FIN_STORED;
          state_next = S_IDLE;
        end
      end
      S_FIN_DROP: begin
        if (st.out_free) begin
          op = OP_FIN_DROP;
          state_next = S_IDLE;
        end
      end
      S_FIN_RUN: begin
        if (st.out_free) begin
          op = OP_FIN_RUN;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_next = S_FIN_RUN;
        end else if (st.scan_hit) begin
          if (st.out_free) begin
            op = OP_START;
            state_next = (st.kind == KIND_DFS) ? S_D_PUSH : S_B_POP;
          end
        end else begin
          op = OP_SCAN_NEXT;
        end
      end
      S_B_POP: begin
        if (st.q_empty) begin
          state_next = S_SCAN;
        end else begin
          op = OP_B_POP;
          state_next = S_B_HEAD;
        end
      end
      S_B_HEAD: begin
        op = OP_B_HEAD;
        state_next = S_B_LIST;
      end
      S_B_LIST: begin
        op = OP_B_LIST;
        state_next = S_B_ENT;
      end
      S_B_ENT: begin
        if (st.out_free) begin
          op = OP_B_ENT;
          state_next = st.list_end ? S_B_POP : S_B_ENT;
        end
      end
      S_D_PUSH: begin
        op = OP_D_PUSH;
        state_next = S_D_TOP;
      end
      S_D_TOP: begin
        if (st.stack_empty) begin
          state_next = S_SCAN;
        end else begin
          op = OP_D_RD;
          state_next = S_D_CHK;
        end
      end
      S_D_CHK: begin
        if (st.top_done) begin
          op = OP_D_POP;
          state_next = S_D_TOP;
        end else begin
          op = OP_D_ENTRD;
          state_next = S_D_ENT;
        end
      end
      S_D_ENT: begin
        if (st.out_free) begin
          op = OP_D_ENT;
          state_next = st.tgt_visited ? S_D_TOP : S_D_PUSH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/gbt_dp.sv -----
// datapath: adjacency memories, marks, work queue, stack and result register
module gbt_dp import gbt_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  gbt_op_t     op,
  output gbt_status_t st,
  input  logic [1:0]  kind,
  input  logic [5:0]  node_a,
  input  logic [5:0]  node_b,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  result_kind,
  output logic [5:0]  node_id,
  output logic        component_start,
  output logic        last
);

  localparam int NN = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int NW = $clog2(NN);
  localparam int EN = 2 * MAX_EDGES;
  localparam int EW = $clog2(EN);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int SW = 2 * EW + 1;

  logic [1:0]    kind_r;
  logic [5:0]    a_r, b_r;
  logic [NW-1:0] a_n, b_n;
  logic [CW-1:0] edge_count;
  logic [EW-1:0] e0, e1;

  logic [NN-1:0] present, visited;

  logic [EW-1:0] head_mem [NN];
  logic [EW-1:0] tail_mem [NN];
  logic [NW-1:0] tgt_mem  [EN];
  logic [EW-1:0] nxt_mem  [EN];
  logic [NW-1:0] q_mem    [NN];
  logic [SW-1:0] stk_mem  [NN];

  logic [EW-1:0] head_rd, tail_rd, nxt_rd;
  logic [NW-1:0] tgt_rd, q_rd;
  logic [SW-1:0] stk_rd;

  logic          node_re, ent_re, head_we, tail_we, tgt_we, nxt_we, q_we, q_re;
  logic          stk_we, stk_re;
  logic [NW-1:0] node_raddr, head_waddr, tail_waddr, q_waddr;
  logic [EW-1:0] ent_raddr, head_wdata, tail_wdata, tgt_waddr, nxt_waddr, nxt_wdata;
  logic [NW-1:0] tgt_wdata, q_wdata, stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata;

  logic          has_a, has_b, had_b;
  logic [EW-1:0] link_a, link_b, link_b_next;
  logic [NW:0]   scan, rd, wr, depth;
  logic [NW-1:0] scan_n, depth_top;
  logic [EW-1:0] cur, endc;
  logic          list_end, tgt_vis;

  logic          visit;
  logic [NW-1:0] visit_node;
  logic          visit_cs;
  logic          pend_valid, pend_cs;
  logic [NW-1:0] pend_node;
  logic          out_free;

  assign a_n       = a_r[NW-1:0];
  assign b_n       = b_r[NW-1:0];
  assign e0        = {edge_count[EW-2:0], 1'b0};
  assign e1        = {edge_count[EW-2:0], 1'b1};
  assign scan_n    = scan[NW-1:0];
  assign depth_top = NW'(depth - 1'b1);
  assign list_end  = (cur == endc);
  assign tgt_vis   = visited[tgt_rd];
  assign out_free  = !res_valid || res_ready;
  assign had_b       = (a_r == b_r) ? 1'b1 : present[b_n];
  assign link_b_next = (a_r == b_r) ? e0 : tail_rd;

  always_comb begin
    st.kind        = kind_r;
    st.drop        = (edge_count == CW'(MAX_EDGES)) || ({1'b0, a_r} >= 7'(NN))
                     || ({1'b0, b_r} >= 7'(NN));
    st.scan_done   = (scan == (NW+1)'(NN));
    st.scan_hit    = present[scan_n] && !visited[scan_n];
    st.q_empty     = (rd == wr);
    st.list_end    = list_end;
    st.tgt_visited = tgt_vis;
    st.stack_empty = (depth == '0);
    st.top_done    = stk_rd[0];
    st.out_free    = out_free;
  end

  // memory port selection
  always_comb begin
    node_re = 1'b0;   node_raddr = a_n;
    ent_re  = 1'b0;   ent_raddr  = head_rd;
    head_we = 1'b0;   head_waddr = a_n;  head_wdata = e0;
    tail_we = 1'b0;   tail_waddr = a_n;  tail_wdata = e0;
    tgt_we  = 1'b0;   tgt_waddr  = e0;   tgt_wdata  = b_n;
    nxt_we  = 1'b0;   nxt_waddr  = link_a; nxt_wdata = e0;
    q_we    = 1'b0;   q_waddr    = wr[NW-1:0]; q_wdata = scan_n;
    q_re    = 1'b0;
    stk_we  = 1'b0;   stk_waddr  = depth[NW-1:0]; stk_wdata = {head_rd, tail_rd, 1'b0};
    stk_re  = 1'b0;   stk_raddr  = depth_top;
    visit   = 1'b0;   visit_node = scan_n; visit_cs = 1'b0;
    case (op)
      OP_ADD_RA: begin
        node_re = 1'b1;
      end
      OP_ADD_WA: begin
        node_re = 1'b1;  node_raddr = b_n;
        head_we = !present[a_n];
        tail_we = 1'b1;
        tgt_we  = 1'b1;
      end
      OP_ADD_WB: begin
        nxt_we  = has_a;
        tgt_we  = 1'b1;  tgt_waddr = e1;  tgt_wdata = a_n;
        head_we = !had_b; head_waddr = b_n; head_wdata = e1;
        tail_we = 1'b1;  tail_waddr = b_n; tail_wdata = e1;
      end
      OP_ADD_LINK: begin
        nxt_we = has_b;  nxt_waddr = link_b;  nxt_wdata = e1;
      end
      OP_START: begin
        node_re = 1'b1;  node_raddr = scan_n;
        q_we    = (kind_r == KIND_BFS);  q_waddr = '0;
        visit   = 1'b1;  visit_cs = 1'b1;
      end
      OP_B_POP: begin
        q_re = 1'b1;
      end
      OP_B_HEAD: begin
        node_re = 1'b1;  node_raddr = q_rd;
      end
      OP_B_LIST: begin
        ent_re = 1'b1;
      end
      OP_B_ENT: begin
        ent_re  = 1'b1;  ent_raddr = nxt_rd;
        q_we    = !tgt_vis;  q_wdata = tgt_rd;
        visit   = !tgt_vis;  visit_node = tgt_rd;
      end
      OP_D_PUSH: begin
        stk_we = 1'b1;
      end
      OP_D_RD: begin
        stk_re = 1'b1;
      end
      OP_D_ENTRD: begin
        ent_re = 1'b1;  ent_raddr = stk_rd[SW-1 -: EW];
      end
      OP_D_ENT: begin
        stk_we  = 1'b1;  stk_waddr = depth_top;  stk_wdata = {nxt_rd, endc, list_end};
        node_re = 1'b1;  node_raddr = tgt_rd;
        visit   = !tgt_vis;  visit_node = tgt_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_re) begin
      head_rd <= head_mem[node_raddr];
      tail_rd <= tail_mem[node_raddr];
    end
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      tgt_rd <= tgt_mem[ent_raddr];
      nxt_rd <= nxt_mem[ent_raddr];
    end
    if (tgt_we) tgt_mem[tgt_waddr] <= tgt_wdata;
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
  end

  always_ff @(posedge clk) begin
    if (q_re) q_rd <= q_mem[rd[NW-1:0]];
    if (q_we) q_mem[q_waddr] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (stk_re) stk_rd <= stk_mem[stk_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
  end

  // transaction capture and edge bookkeeping
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      kind_r <= kind;
      a_r    <= node_a;
      b_r    <= node_b;
    end
    if (op == OP_ADD_WA) begin
      has_a  <= present[a_n];
      link_a <= tail_rd;
    end
    if (op == OP_ADD_WB) begin
      has_b  <= had_b;
      link_b <= link_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      edge_count <= '0;
    end else begin
      if (op == OP_ADD_WA) present[a_n] <= 1'b1;
      if (op == OP_ADD_WB) present[b_n] <= 1'b1;
      if (op == OP_ADD_LINK) edge_count <= edge_count + 1'b1;
    end
  end

  // traversal control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      visited    <= '0;
      scan       <= '0;
      rd         <= '0;
      wr         <= '0;
      depth      <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (op)
        OP_RUN_INIT: begin
          visited    <= '0;
          scan       <= '0;
          pend_valid <= 1'b0;
        end
        OP_SCAN_NEXT: scan <= scan + 1'b1;
        OP_START: begin
          rd    <= '0;
          wr    <= (NW+1)'(1);
          depth <= '0;
        end
        OP_B_POP: rd <= rd + 1'b1;
        OP_B_ENT: if (!tgt_vis) wr <= wr + 1'b1;
        OP_D_PUSH: depth <= depth + 1'b1;
        OP_D_POP: depth <= depth - 1'b1;
        OP_FIN_RUN: pend_valid <= 1'b0;
        default: begin
        end
      endcase
      if (visit) begin
        visited[visit_node] <= 1'b1;
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_B_LIST) begin
      cur  <= head_rd;
      endc <= tail_rd;
    end else if (op == OP_B_ENT) begin
      cur <= nxt_rd;
    end else if (op == OP_D_ENTRD) begin
      cur  <= stk_rd[SW-1 -: EW];
      endc <= stk_rd[EW:1];
    end
    if (visit) begin
      pend_node <= visit_node;
      pend_cs   <= visit_cs;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((visit && pend_valid) || op == OP_FIN_STORED || op == OP_FIN_DROP
                 || op == OP_FIN_RUN) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (visit && pend_valid) begin
      result_kind     <= RES_VISIT;
      node_id         <= 6'(pend_node);
      component_start <= pend_cs;
      last            <= 1'b0;
    end else if (op == OP_FIN_RUN && pend_valid) begin
      result_kind     <= RES_VISIT;
      node_id         <= 6'(pend_node);
      component_start <= pend_cs;
      last            <= 1'b1;
    end else if (op == OP_FIN_RUN || op == OP_FIN_STORED || op == OP_FIN_DROP) begin
      result_kind     <= (op == OP_FIN_RUN) ? RES_EMPTY :
                         (op == OP_FIN_DROP) ? RES_DROPPED : RES_STORED;
      node_id         <= '0;
      component_start <= 1'b0;
      last            <= 1'b1;
    end
  end

endmodule

// ----- sv/graph_bfs_dfs_traversal.sv -----
// top level: undirected graph store with breadth-first and depth-first walks
// edge add: decode, ADD_A..ADD_D, finish; dropped edge: decode, finish; the finish
//   state loads the result register when it is free. run: 1 node scanned per cycle,
//   list entries 1 per cycle (breadth-first) unless results stall; one item at a time
// results stall on res_ready through a single output register
// reset clears the graph (present marks, edge count) and all control state
module graph_bfs_dfs_traversal import gbt_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [1:0] kind,
  input  logic [5:0] node_a,
  input  logic [5:0] node_b,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] result_kind,
  output logic [5:0] node_id,
  output logic       component_start,
  output logic       last
);

  gbt_op_t     op;
  gbt_status_t st;

  gbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .st        (st),
    .op        (op)
  );

  gbt_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .st              (st),
    .kind            (kind),
    .node_a          (node_a),
    .node_b          (node_b),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .result_kind     (result_kind),
    .node_id         (node_id),
    .component_start (component_start),
    .last            (last)
  );

endmodule
